>>> src/bcdba_pkg.sv
// Shared constants, types and helpers of the decimal arithmetic unit.
`timescale 1ns / 1ps
package bcdba_pkg;

  localparam int DIGITS     = 32;
  localparam int IDX_W      = 5;
  localparam int PROD_DEPTH = 2 * DIGITS;
  localparam int PROD_AW    = 6;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  typedef enum logic [2:0] {
    KIND_CLEAR   = 3'd0,
    KIND_LOAD_A  = 3'd1,
    KIND_LOAD_B  = 3'd2,
    KIND_COMPUTE = 3'd3,
    KIND_READ    = 3'd4
  } kind_t;

  localparam logic [2:0] SEL_SUM  = 3'd0;
  localparam logic [2:0] SEL_DIFF = 3'd1;
  localparam logic [2:0] SEL_PROD = 3'd2;
  localparam logic [2:0] SEL_QUOT = 3'd3;
  localparam logic [2:0] SEL_REM  = 3'd4;

  typedef struct packed {
    kind_t       op;
    logic [5:0]  idx;
    logic [3:0]  val;
    logic [2:0]  sel;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_ADD,
    ST_SUB,
    ST_MUL_RD,
    ST_MUL_WR,
    ST_MUL_CARRY,
    ST_DIV_INIT,
    ST_DIV_SHIFT,
    ST_DIV_CMP,
    ST_DIV_SUB,
    ST_REM_LEN
  } state_t;

  // Quotient by ten for values up to 99, by reciprocal multiply.
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [17:0] p;
    p = {11'b0, v} * 18'd205;
    return p[14:11];
  endfunction

endpackage

>>> src/bcd_bignum_arith_unit_core.sv
// Top level of the decimal add/subtract/multiply/divide unit.
//
//   channel   ports                                   handshake
//   input     in_kind in_digit_index in_digit_value   start && !busy
//             in_result_select
//   result    out_digit out_result_length             out_valid, one cycle
//             out_negative out_divide_by_zero
//
// A four-deep queue sits between intake and execution; busy is high when it is full.
// Clear and load items retire in ST_IDLE; a read item passes through ST_RD and its
// result is registered. A compute item runs sum and difference passes, product rows
// (a read and write per partial product, a carry write per row), a divisor test and,
// for a nonzero divisor, per quotient digit a shift, a compare and a subtract and
// compare per unit of the digit, then remainder sizing. Reset is synchronous; all
// stores read as zero and lengths as 1. Results cannot be held off by the receiver.
`timescale 1ns / 1ps
module bcd_bignum_arith_unit_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_kind,
  input  logic [5:0] in_digit_index,
  input  logic [3:0] in_digit_value,
  input  logic [2:0] in_result_select,
  output logic       out_valid,
  output logic [3:0] out_digit,
  output logic [6:0] out_result_length,
  output logic       out_negative,
  output logic       out_divide_by_zero
);
  import bcdba_pkg::*;

  head_t head;
  logic  pop;

  bcdba_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_digit_index   (in_digit_index),
    .in_digit_value   (in_digit_value),
    .in_result_select (in_result_select),
    .head             (head),
    .pop              (pop)
  );

  bcdba_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_digit          (out_digit),
    .out_result_length  (out_result_length),
    .out_negative       (out_negative),
    .out_divide_by_zero (out_divide_by_zero)
  );

  // a read passes through ST_IDLE and ST_RD in execution, so strobes never touch
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // the queue only fills through accepted items
  assert property (@(posedge clk) disable iff (!rst_n) $rose(busy) |-> $past(start))
    else $error("queue filled without an accepted item");

  assert property (@(posedge clk) !rst_n |=> (!busy && !out_valid))
    else $error("busy or strobe right after reset");

  // a result length never exceeds the product depth
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_length != 7'd0 && out_result_length <= 7'(PROD_DEPTH)))
    else $error("result length out of range");

endmodule

>>> src/bcdba_front.sv
// Intake: accepts items, classifies them and queues them for the execution side.
`timescale 1ns / 1ps
module bcdba_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_kind,
  input  logic [5:0]          in_digit_index,
  input  logic [3:0]          in_digit_value,
  input  logic [2:0]          in_result_select,
  output bcdba_pkg::head_t    head,
  input  logic                pop
);
  import bcdba_pkg::*;

  item_t             q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              accept, keep, push, do_pop;
  item_t             cls;

  assign busy   = (count_r == (QPTR_W+1)'(QDEPTH));
  assign accept = start && !busy;

  always_comb begin
    cls.op  = kind_t'(in_kind);
    cls.idx = in_digit_index;
    cls.val = (in_digit_value > 4'd9) ? 4'd9 : in_digit_value;
    cls.sel = in_result_select;
    unique case (in_kind)
      KIND_CLEAR, KIND_COMPUTE, KIND_READ: keep = 1'b1;
      KIND_LOAD_A, KIND_LOAD_B:            keep = !in_digit_index[5];
      default:                             keep = 1'b0;
    endcase
  end

  assign push   = accept && keep;
  assign do_pop = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> src/bcdba_back.sv
// Execution: operand and result stores, digit-serial arithmetic sequencer, read path.
`timescale 1ns / 1ps
module bcdba_back (
  input  logic              clk,
  input  logic              rst_n,
  input  bcdba_pkg::head_t  head,
  output logic              pop,
  output logic              out_valid,
  output logic [3:0]        out_digit,
  output logic [6:0]        out_result_length,
  output logic              out_negative,
  output logic              out_divide_by_zero
);
  import bcdba_pkg::*;

  state_t state_r, state_nxt;

  logic [3:0] opa_r [DIGITS];
  logic [3:0] opb_r [DIGITS];
  logic [3:0] sum_r [DIGITS];
  logic [3:0] diff_r [DIGITS];
  logic [3:0] quot_r [DIGITS];
  logic [3:0] rem_r [DIGITS];
  logic [3:0] prod_mem [PROD_DEPTH];
  logic [3:0] mem_q_r;

  logic [3:0] sum_hi_r, rem_hi_r;
  logic [6:0] len_sum_r, len_diff_r, len_prod_r, len_quot_r, len_rem_r;
  logic       neg_r, dz_r, prod_ever_r, lt_r, bz_r, borrow_r, qfound_r;
  logic [3:0] carry_r, q_r;
  logic [5:0] k_r;
  logic [IDX_W-1:0] i_r;
  item_t      cur_r;

  logic       out_valid_r;
  logic [3:0] out_digit_r;
  logic [6:0] out_len_r;

  logic [IDX_W-1:0]   a_ra, b_ra, rem_ra;
  logic [3:0]         a_d, b_d, rem_d;
  logic [4:0]         s_raw;
  logic [3:0]         s_dig;
  logic               s_c, lt_nxt;
  logic [3:0]         sub_x, sub_y, sub_dig;
  logic [4:0]         sub_raw;
  logic               sub_neg;
  logic [3:0]         mul_old, mq, mdig;
  logic [6:0]         mv, mtmp;
  logic [PROD_AW-1:0] pos;
  logic               mem_we;
  logic [PROD_AW-1:0] mem_wa, mem_ra;
  logic [3:0]         mem_wd;
  logic               k_last, k_top, go_sub;
  logic [3:0]         rd_digit;
  logic [6:0]         rd_len;

  // Read ports of the flip-flop stores, one address each.
  assign a_ra   = (state_r == ST_DIV_SHIFT) ? i_r : k_r[IDX_W-1:0];
  assign b_ra   = (state_r == ST_MUL_RD || state_r == ST_MUL_WR) ? i_r : k_r[IDX_W-1:0];
  assign rem_ra = (state_r == ST_RD) ? cur_r.idx[IDX_W-1:0] : k_r[IDX_W-1:0];
  assign a_d    = opa_r[a_ra];
  assign b_d    = opb_r[b_ra];
  assign rem_d  = rem_r[rem_ra];

  assign k_last = (k_r == 6'(DIGITS - 1));
  assign k_top  = (k_r == 6'(DIGITS));

  always_comb begin
    s_raw = {1'b0, a_d} + {1'b0, b_d} + {4'b0, carry_r[0]};
    s_c   = (s_raw > 5'd9);
    s_dig = s_c ? 4'(s_raw - 5'd10) : s_raw[3:0];
    if (a_d < b_d) begin
      lt_nxt = 1'b1;
    end else if (a_d > b_d) begin
      lt_nxt = 1'b0;
    end else begin
      lt_nxt = lt_r;
    end
  end

  // Shared digit subtractor: difference pass and division trial/subtract.
  always_comb begin
    if (state_r == ST_SUB) begin
      sub_x = lt_r ? b_d : a_d;
      sub_y = lt_r ? a_d : b_d;
    end else begin
      sub_x = k_r[5] ? rem_hi_r : rem_d;
      sub_y = k_r[5] ? 4'd0 : b_d;
    end
    sub_raw = {1'b0, sub_x} - {1'b0, sub_y} - {4'b0, borrow_r};
    sub_neg = sub_raw[4];
    sub_dig = sub_neg ? (sub_raw[3:0] + 4'd10) : sub_raw[3:0];
  end

  assign go_sub = !sub_neg && (q_r < 4'd9);

  always_comb begin
    mul_old = (i_r == '0) ? 4'd0 : mem_q_r;
    mv      = {3'b0, mul_old} + ({3'b0, a_d} * {3'b0, b_d}) + {3'b0, carry_r};
    mq      = div10(mv);
    mtmp    = mv - ({3'b0, mq} * 7'd10);
    mdig    = mtmp[3:0];
    pos     = {1'b0, i_r} + {1'b0, k_r[IDX_W-1:0]};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid && head.item.op == KIND_COMPUTE) begin
          state_nxt = ST_ADD;
        end else if (head.valid && head.item.op == KIND_READ) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD:        state_nxt = ST_IDLE;
      ST_ADD:       if (k_last) state_nxt = ST_SUB;
      ST_SUB:       if (k_last) state_nxt = ST_MUL_RD;
      ST_MUL_RD:    state_nxt = ST_MUL_WR;
      ST_MUL_WR:    state_nxt = k_last ? ST_MUL_CARRY : ST_MUL_RD;
      ST_MUL_CARRY: state_nxt = (i_r == IDX_W'(DIGITS - 1)) ? ST_DIV_INIT : ST_MUL_RD;
      ST_DIV_INIT:  state_nxt = bz_r ? ST_IDLE : ST_DIV_SHIFT;
      ST_DIV_SHIFT: state_nxt = ST_DIV_CMP;
      ST_DIV_CMP: begin
        if (k_top) begin
          if (go_sub) begin
            state_nxt = ST_DIV_SUB;
          end else if (i_r == '0) begin
            state_nxt = ST_REM_LEN;
          end else begin
            state_nxt = ST_DIV_SHIFT;
          end
        end
      end
      ST_DIV_SUB:   if (k_top) state_nxt = ST_DIV_CMP;
      ST_REM_LEN:   if (k_last) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs: queue pop and product memory port.
  always_comb begin
    pop    = 1'b0;
    mem_we = 1'b0;
    mem_wa = pos;
    mem_wd = mdig;
    mem_ra = pos;
    unique case (state_r)
      ST_IDLE: begin
        pop    = head.valid;
        mem_ra = head.item.idx;
      end
      ST_MUL_WR: begin
        mem_we = 1'b1;
      end
      ST_MUL_CARRY: begin
        mem_we = 1'b1;
        mem_wa = {1'b1, i_r};
        mem_wd = carry_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      prod_mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= prod_mem[mem_ra];
  end

  // Read selection for the item in cur_r.
  always_comb begin
    rd_digit = 4'd0;
    rd_len   = 7'd1;
    unique case (cur_r.sel)
      SEL_SUM: begin
        rd_len = len_sum_r;
        if (!cur_r.idx[5]) begin
          rd_digit = sum_r[cur_r.idx[IDX_W-1:0]];
        end else if (cur_r.idx == 6'(DIGITS)) begin
          rd_digit = sum_hi_r;
        end
      end
      SEL_DIFF: begin
        rd_len = len_diff_r;
        if (!cur_r.idx[5]) rd_digit = diff_r[cur_r.idx[IDX_W-1:0]];
      end
      SEL_PROD: begin
        rd_len = len_prod_r;
        if (prod_ever_r) rd_digit = mem_q_r;
      end
      SEL_QUOT: begin
        rd_len = len_quot_r;
        if (!dz_r && !cur_r.idx[5]) rd_digit = quot_r[cur_r.idx[IDX_W-1:0]];
      end
      SEL_REM: begin
        rd_len = len_rem_r;
        if (!dz_r && !cur_r.idx[5]) rd_digit = rem_d;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      dz_r        <= 1'b0;
      prod_ever_r <= 1'b0;
      len_sum_r   <= 7'd1;
      len_diff_r  <= 7'd1;
      len_prod_r  <= 7'd1;
      len_quot_r  <= 7'd1;
      len_rem_r   <= 7'd1;
      sum_hi_r    <= 4'd0;
      rem_hi_r    <= 4'd0;
      k_r         <= '0;
      i_r         <= '0;
      for (int n = 0; n < DIGITS; n++) begin
        opa_r[n]  <= 4'd0;
        opb_r[n]  <= 4'd0;
        sum_r[n]  <= 4'd0;
        diff_r[n] <= 4'd0;
        quot_r[n] <= 4'd0;
        rem_r[n]  <= 4'd0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_RD);
      unique case (state_r)
        ST_IDLE: begin
          cur_r <= head.item;
          if (head.valid) begin
            unique case (head.item.op)
              KIND_CLEAR: begin
                for (int n = 0; n < DIGITS; n++) begin
                  opa_r[n] <= 4'd0;
                  opb_r[n] <= 4'd0;
                end
              end
              KIND_LOAD_A: opa_r[head.item.idx[IDX_W-1:0]] <= head.item.val;
              KIND_LOAD_B: opb_r[head.item.idx[IDX_W-1:0]] <= head.item.val;
              KIND_COMPUTE: begin
                k_r       <= '0;
                carry_r   <= 4'd0;
                lt_r      <= 1'b0;
                bz_r      <= 1'b1;
                len_sum_r <= 7'd1;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RD: begin
          out_digit_r <= rd_digit;
          out_len_r   <= rd_len;
        end
        ST_ADD: begin
          sum_r[k_r[IDX_W-1:0]] <= s_dig;
          carry_r <= {3'b0, s_c};
          lt_r    <= lt_nxt;
          if (b_d != 4'd0) bz_r <= 1'b0;
          if (k_last) begin
            sum_hi_r   <= {3'b0, s_c};
            len_sum_r  <= s_c ? 7'(DIGITS + 1) :
                          (s_dig != 4'd0) ? ({1'b0, k_r} + 7'd1) : len_sum_r;
            neg_r      <= lt_nxt;
            k_r        <= '0;
            borrow_r   <= 1'b0;
            len_diff_r <= 7'd1;
          end else begin
            if (s_dig != 4'd0) len_sum_r <= {1'b0, k_r} + 7'd1;
            k_r <= k_r + 6'd1;
          end
        end
        ST_SUB: begin
          diff_r[k_r[IDX_W-1:0]] <= sub_dig;
          borrow_r <= sub_neg;
          if (sub_dig != 4'd0) len_diff_r <= {1'b0, k_r} + 7'd1;
          if (k_last) begin
            k_r        <= '0;
            i_r        <= '0;
            carry_r    <= 4'd0;
            len_prod_r <= 7'd1;
          end else begin
            k_r <= k_r + 6'd1;
          end
        end
        ST_MUL_WR: begin
          carry_r <= mq;
          // a position is final at its first column or in the last row
          if ((k_r == '0 || i_r == IDX_W'(DIGITS - 1)) && mdig != 4'd0) begin
            len_prod_r <= {1'b0, pos} + 7'd1;
          end
          k_r <= k_last ? 6'd0 : (k_r + 6'd1);
        end
        ST_MUL_CARRY: begin
          carry_r <= 4'd0;
          if (i_r == IDX_W'(DIGITS - 1)) begin
            if (carry_r != 4'd0) len_prod_r <= 7'(PROD_DEPTH);
            prod_ever_r <= 1'b1;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        ST_DIV_INIT: begin
          dz_r <= bz_r;
          len_quot_r <= 7'd1;
          len_rem_r  <= 7'd1;
          if (!bz_r) begin
            for (int n = 0; n < DIGITS; n++) begin
              rem_r[n] <= 4'd0;
            end
            rem_hi_r <= 4'd0;
            i_r      <= IDX_W'(DIGITS - 1);
            qfound_r <= 1'b0;
          end
        end
        ST_DIV_SHIFT: begin
          rem_r[0] <= a_d;
          for (int n = 1; n < DIGITS; n++) begin
            rem_r[n] <= rem_r[n-1];
          end
          rem_hi_r <= rem_r[DIGITS-1];
          q_r      <= 4'd0;
          k_r      <= '0;
          borrow_r <= 1'b0;
        end
        ST_DIV_CMP: begin
          if (k_top) begin
            k_r      <= '0;
            borrow_r <= 1'b0;
            if (!go_sub) begin
              quot_r[i_r] <= q_r;
              if (q_r != 4'd0 && !qfound_r) begin
                len_quot_r <= {2'b0, i_r} + 7'd1;
                qfound_r   <= 1'b1;
              end
              if (i_r != '0) i_r <= i_r - 1'b1;
            end
          end else begin
            borrow_r <= sub_neg;
            k_r      <= k_r + 6'd1;
          end
        end
        ST_DIV_SUB: begin
          if (k_r[5]) begin
            rem_hi_r <= sub_dig;
          end else begin
            rem_r[k_r[IDX_W-1:0]] <= sub_dig;
          end
          if (k_top) begin
            k_r      <= '0;
            borrow_r <= 1'b0;
            q_r      <= q_r + 4'd1;
          end else begin
            borrow_r <= sub_neg;
            k_r      <= k_r + 6'd1;
          end
        end
        ST_REM_LEN: begin
          if (rem_d != 4'd0) len_rem_r <= {1'b0, k_r} + 7'd1;
          k_r <= k_r + 6'd1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_digit          = out_digit_r;
  assign out_result_length  = out_len_r;
  assign out_negative       = neg_r;
  assign out_divide_by_zero = dz_r;

endmodule

>>> tb/bcdba_checker.sv
// Watches both channels of the decimal unit, predicts each read result and compares it.
`timescale 1ns / 1ps
module bcdba_checker
  import bcdba_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [2:0] in_kind,
  input  logic [5:0] in_digit_index,
  input  logic [3:0] in_digit_value,
  input  logic [2:0] in_result_select,
  input  logic       out_valid,
  input  logic [3:0] out_digit,
  input  logic [6:0] out_result_length,
  input  logic       out_negative,
  input  logic       out_divide_by_zero,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [3:0] digit;
    logic [6:0] length;
    logic       neg;
    logic       dz;
  } read_result_t;

  logic [3:0] opnd_a [DIGITS];
  logic [3:0] opnd_b [DIGITS];
  logic [3:0] sum_d  [DIGITS+1];
  logic [3:0] diff_d [DIGITS];
  logic [3:0] prod_d [PROD_DEPTH];
  logic [3:0] quo_d  [DIGITS];
  logic [3:0] rem_d  [DIGITS];
  logic [3:0] wrem   [DIGITS+1];
  logic [3:0] wdiv   [DIGITS+1];
  int         len_d  [5];
  logic       neg_flag;
  logic       dz_flag;
  read_result_t read_q[$];

  assign pending = read_q.size();

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  task automatic clear_all();
    for (int i = 0; i < DIGITS; i++) begin
      opnd_a[i] = 0; opnd_b[i] = 0; diff_d[i] = 0; quo_d[i] = 0; rem_d[i] = 0;
    end
    for (int i = 0; i <= DIGITS; i++) sum_d[i] = 0;
    for (int i = 0; i < PROD_DEPTH; i++) prod_d[i] = 0;
    for (int i = 0; i < 5; i++) len_d[i] = 1;
    neg_flag = 0;
    dz_flag = 0;
  endtask

  function automatic bit wide_ge();
    for (int i = DIGITS; i >= 0; i--) begin
      if (wrem[i] < wdiv[i]) return 0;
      if (wrem[i] > wdiv[i]) return 1;
    end
    return 1;
  endfunction

  task automatic wide_sub();
    int d, br;
    br = 0;
    for (int i = 0; i <= DIGITS; i++) begin
      d = int'(wrem[i]) - int'(wdiv[i]) - br;
      br = 0;
      if (d < 0) begin
        d += 10;
        br = 1;
      end
      wrem[i] = d[3:0];
    end
  endtask

  task automatic compute_results();
    int c, s, d, br, cmp, q;
    int col [PROD_DEPTH];
    bit zero_b;
    c = 0;
    for (int i = 0; i < DIGITS; i++) begin
      s = opnd_a[i] + opnd_b[i] + c;
      c = (s > 9);
      if (c) s -= 10;
      sum_d[i] = s[3:0];
    end
    sum_d[DIGITS] = c[3:0];
    len_d[0] = 1;
    for (int i = DIGITS; i > 0; i--) if (sum_d[i] != 0 && len_d[0] == 1) len_d[0] = i + 1;

    cmp = 0;
    for (int i = DIGITS - 1; i >= 0 && cmp == 0; i--) begin
      if (opnd_a[i] < opnd_b[i]) cmp = -1;
      else if (opnd_a[i] > opnd_b[i]) cmp = 1;
    end
    neg_flag = (cmp < 0);
    br = 0;
    for (int i = 0; i < DIGITS; i++) begin
      d = neg_flag ? int'(opnd_b[i]) - int'(opnd_a[i]) - br
                   : int'(opnd_a[i]) - int'(opnd_b[i]) - br;
      br = 0;
      if (d < 0) begin
        d += 10;
        br = 1;
      end
      diff_d[i] = d[3:0];
    end
    len_d[1] = 1;
    for (int i = DIGITS - 1; i > 0; i--) if (diff_d[i] != 0 && len_d[1] == 1) len_d[1] = i + 1;

    for (int i = 0; i < PROD_DEPTH; i++) col[i] = 0;
    for (int i = 0; i < DIGITS; i++)
      for (int j = 0; j < DIGITS; j++) col[i+j] += opnd_a[j] * opnd_b[i];
    c = 0;
    for (int i = 0; i < PROD_DEPTH; i++) begin
      s = col[i] + c;
      prod_d[i] = 4'(s % 10);
      c = s / 10;
    end
    len_d[2] = 1;
    for (int i = PROD_DEPTH - 1; i > 0; i--)
      if (prod_d[i] != 0 && len_d[2] == 1) len_d[2] = i + 1;

    zero_b = 1;
    for (int i = 0; i < DIGITS; i++) if (opnd_b[i] != 0) zero_b = 0;
    dz_flag = zero_b;
    if (zero_b) begin
      for (int i = 0; i < DIGITS; i++) begin
        quo_d[i] = 0;
        rem_d[i] = 0;
      end
      len_d[3] = 1;
      len_d[4] = 1;
      return;
    end
    for (int i = 0; i <= DIGITS; i++) begin
      wrem[i] = 0;
      wdiv[i] = (i < DIGITS) ? opnd_b[i] : 4'd0;
    end
    for (int i = DIGITS - 1; i >= 0; i--) begin
      for (int k = DIGITS; k > 0; k--) wrem[k] = wrem[k-1];
      wrem[0] = opnd_a[i];
      q = 0;
      while (q < 9 && wide_ge()) begin
        wide_sub();
        q++;
      end
      quo_d[i] = q[3:0];
    end
    for (int i = 0; i < DIGITS; i++) rem_d[i] = wrem[i];
    len_d[3] = 1;
    len_d[4] = 1;
    for (int i = DIGITS - 1; i > 0; i--) begin
      if (quo_d[i] != 0 && len_d[3] == 1) len_d[3] = i + 1;
      if (rem_d[i] != 0 && len_d[4] == 1) len_d[4] = i + 1;
    end
  endtask

  task automatic predict_item(input logic [2:0] k, input logic [5:0] idx,
                              input logic [3:0] val, input logic [2:0] sel);
    read_result_t r;
    logic [3:0] v;
    v = (val > 9) ? 4'd9 : val;
    case (k)
      KIND_CLEAR: begin
        for (int i = 0; i < DIGITS; i++) begin
          opnd_a[i] = 0;
          opnd_b[i] = 0;
        end
      end
      KIND_LOAD_A: if (idx < DIGITS) opnd_a[idx] = v;
      KIND_LOAD_B: if (idx < DIGITS) opnd_b[idx] = v;
      KIND_COMPUTE: compute_results();
      KIND_READ: begin
        r.digit = 0;
        r.length = 1;
        r.neg = neg_flag;
        r.dz = dz_flag;
        case (sel)
          SEL_SUM: begin
            r.length = 7'(len_d[0]);
            if (idx <= DIGITS) r.digit = sum_d[idx];
          end
          SEL_DIFF: begin
            r.length = 7'(len_d[1]);
            if (idx < DIGITS) r.digit = diff_d[idx];
          end
          SEL_PROD: begin
            r.length = 7'(len_d[2]);
            r.digit = prod_d[idx];
          end
          SEL_QUOT: begin
            r.length = 7'(len_d[3]);
            if (idx < DIGITS) r.digit = quo_d[idx];
          end
          SEL_REM: begin
            r.length = 7'(len_d[4]);
            if (idx < DIGITS) r.digit = rem_d[idx];
          end
          default: ;
        endcase
        read_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    read_result_t w;
    if (!rst_n) begin
      clear_all();
      read_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (read_q.size() == 0) begin
          $display("result strobed with no read item waiting");
          fail_count++;
        end else begin
          w = read_q.pop_front();
          if (out_digit !== w.digit) report("digit", out_digit, w.digit);
          if (out_result_length !== w.length) report("length", out_result_length, w.length);
          if (out_negative !== w.neg) report("negative", out_negative, w.neg);
          if (out_divide_by_zero !== w.dz) report("divide_by_zero", out_divide_by_zero, w.dz);
        end
      end
      if (start && !busy)
        predict_item(in_kind, in_digit_index, in_digit_value, in_result_select);
    end
  end

endmodule

>>> tb/tb.sv
// Stimulus and verdict for the decimal arithmetic unit.
`timescale 1ns / 1ps
module tb;
  import bcdba_pkg::*;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       start = 0;
  logic       busy;
  logic [2:0] in_kind = 0;
  logic [5:0] in_digit_index = 0;
  logic [3:0] in_digit_value = 0;
  logic [2:0] in_result_select = 0;
  logic       out_valid;
  logic [3:0] out_digit;
  logic [6:0] out_result_length;
  logic       out_negative;
  logic       out_divide_by_zero;
  int         fail_count;
  int         pending;
  int         cycle_count = 0;
  int         sent = 0;

  always #6 clk = ~clk;

  bcd_bignum_arith_unit_core i_dut (.*);

  bcdba_checker i_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 20000000) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic send(input int k, input int idx, input int val, input int sel);
    int gap;
    in_kind <= 3'(k);
    in_digit_index <= 6'(idx);
    in_digit_value <= 4'(val);
    in_result_select <= 3'(sel);
    start <= 1;
    do @(posedge clk); while (busy);
    if (k <= KIND_READ) sent++;
    gap = 0;
    if ($urandom_range(0, 99) < 25) gap = $urandom_range(1, 3);
    else if ($urandom_range(0, 99) < 3) gap = $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_operand(input logic [2:0] k, input int len);
    for (int i = 0; i < len; i++)
      send(k, i, $urandom_range(0, 9), 0);
  endtask

  task automatic read_some(input int n);
    for (int i = 0; i < n; i++)
      send(KIND_READ, $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 7));
  endtask

  function automatic int pick_len();
    if ($urandom_range(0, 99) < 5) return $urandom_range(1, DIGITS);
    return $urandom_range(1, 6);
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // reset values, every selector including unknown ones
    for (int s = 0; s < 8; s++) send(KIND_READ, s * 9, 0, s);
    send(KIND_READ, 63, 0, SEL_PROD);
    // compute with zero divisor, digit saturation, load past the top
    send(KIND_LOAD_A, 0, 15, 0);
    send(KIND_LOAD_A, 40, 5, 0);
    send(KIND_LOAD_B, 63, 7, 0);
    for (int k = 5; k < 8; k++) send(k, 0, 0, 0);
    send(KIND_COMPUTE, 0, 0, 0);
    for (int s = 0; s < 5; s++) send(KIND_READ, 0, 0, s);
    // all nines over one, then a smaller first operand
    for (int i = 0; i < DIGITS; i++) send(KIND_LOAD_A, i, 9, 0);
    send(KIND_LOAD_B, 0, 1, 0);
    send(KIND_COMPUTE, 0, 0, 0);
    send(KIND_READ, 32, 0, SEL_SUM);
    send(KIND_READ, 31, 0, SEL_QUOT);
    send(KIND_READ, 63, 0, SEL_PROD);
    send(KIND_CLEAR, 0, 0, 0);
    send(KIND_READ, 0, 0, SEL_DIFF);
    send(KIND_LOAD_B, 3, 2, 0);
    send(KIND_COMPUTE, 0, 0, 0);
    for (int s = 0; s < 5; s++) send(KIND_READ, $urandom_range(0, 4), 0, s);
    // random sequences with some noise mixed in
    while (sent < 1850) begin
      if ($urandom_range(0, 99) < 12) begin
        send($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 15),
             $urandom_range(0, 7));
      end else begin
        if ($urandom_range(0, 3) != 0) send(KIND_CLEAR, 0, 0, 0);
        load_operand(KIND_LOAD_A, pick_len());
        if ($urandom_range(0, 9) != 0) load_operand(KIND_LOAD_B, pick_len());
        send(KIND_COMPUTE, 0, 0, 0);
        read_some($urandom_range(3, 8));
      end
    end
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (25000) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
